>>> sv/brot_pkg.sv
// Shared types and constants for the byte range ownership tracker.
// No dependencies; used by brot_dpath, brot_ctrl and the top level.
package brot_pkg;

    // Default sizing, handed down as top-level parameter defaults
    localparam int MAX_BYTES_DEF     = 4096;
    localparam int MAP_WORD_BITS_DEF = 64;

    // Fixed field widths
    localparam int OP_W  = 2;
    localparam int POS_W = 13;
    localparam int ST_W  = 3;

    // APB register map: one 32-bit register per word address
    localparam int         ADDR_W      = 3;
    localparam int         DATA_W      = 32;
    localparam logic       REG_LENGTH  = 1'b0;
    localparam logic       REG_ENABLE  = 1'b1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLAIM = 2'd0;
    localparam logic [OP_W-1:0] OP_COVER = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_OFF        = 3'd1;
    localparam logic [ST_W-1:0] ST_BOUNDS     = 3'd2;
    localparam logic [ST_W-1:0] ST_CONFLICT   = 3'd3;
    localparam logic [ST_W-1:0] ST_INCOMPLETE = 3'd4;
    localparam logic [ST_W-1:0] ST_UNCOVERED  = 3'd5;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the incoming beat
        logic start_pass;  // restart the word walk at the range's first word
        logic mark;        // walk writes marks instead of checking
        logic clear;       // drop every row of both maps
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            complete;
        logic            oob;
        logic            empty;
        logic            pass_done;
        logic            fail;
    } t_dp_stat;

endpackage

>>> sv/brot_dpath.sv
// Datapath: range set-up, map memory with per-row valid bits, word walk.
// Depends on brot_pkg; driven by brot_ctrl through t_dp_cmd.
module brot_dpath #(
    parameter int MAX_BYTES     = brot_pkg::MAX_BYTES_DEF,
    parameter int MAP_WORD_BITS = brot_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  brot_pkg::t_dp_cmd            i_cmd,
    input  logic [brot_pkg::OP_W-1:0]    i_op,
    input  logic [brot_pkg::POS_W-1:0]   i_first_byte,
    input  logic [brot_pkg::POS_W-1:0]   i_byte_count,
    input  logic                         i_data_complete,
    input  logic [brot_pkg::POS_W-1:0]   i_buffer_length,
    output brot_pkg::t_dp_stat           o_stat
);

    localparam int WB        = MAP_WORD_BITS;
    localparam int WL        = $clog2(WB);
    localparam int MAP_WORDS = (MAX_BYTES + WB - 1) / WB;
    localparam int WI        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LB        = $clog2(MAX_BYTES + 1);
    // byte positions: room for first+count, MAX_BYTES and one word beyond
    localparam int LW        = (((brot_pkg::POS_W + 1) > LB) ? (brot_pkg::POS_W + 1) : LB) + 1;
    // reciprocal for the word index of the first byte
    localparam int SH        = LW + WL;
    localparam int MW        = SH + 1;
    localparam int PW        = LW + MW;
    localparam logic [MW-1:0] RECIP  = MW'(((64'd1 << SH) + 64'(WB) - 64'd1) / 64'(WB));
    localparam logic [LW-1:0] WB_L   = LW'(WB);
    localparam logic [LW-1:0] MAXB_L = LW'(MAX_BYTES);

    // range set-up from the incoming beat
    logic [LW-1:0] w_len_raw, w_len, w_first, w_end, w_lo, w_hi;
    logic          w_is_query, w_oob;
    logic [PW-1:0] w_prod;

    assign w_len_raw  = LW'(i_buffer_length);
    assign w_len      = (w_len_raw > MAXB_L) ? MAXB_L : w_len_raw;
    assign w_first    = LW'(i_first_byte);
    assign w_end      = w_first + LW'(i_byte_count);
    assign w_is_query = (i_op == brot_pkg::OP_QUERY);
    assign w_lo       = w_is_query ? '0 : w_first;
    assign w_hi       = w_is_query ? w_len : w_end;
    assign w_oob      = (w_first > w_len) || (w_end > w_len);
    assign w_prod     = PW'(w_lo) * PW'(RECIP);

    logic [brot_pkg::OP_W-1:0] r_op;
    logic                      r_complete, r_oob, r_empty;
    logic [LW-1:0]             r_lo, r_hi, r_start_base;
    logic [WI-1:0]             r_q;

    // capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_complete <= i_data_complete;
            r_oob      <= w_oob;
            r_empty    <= (w_lo == w_hi);
            r_lo       <= w_lo;
            r_hi       <= w_hi;
            r_q        <= w_prod[SH +: WI];
        end
        r_start_base <= LW'(r_q) * WB_L;
    end

    // read side of the walk
    logic          r_issuing;
    logic [WI-1:0] r_rd_word;
    logic [LW-1:0] r_rd_base;
    logic          w_rd_last;

    assign w_rd_last = (r_rd_base + WB_L) >= r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
        end else if (i_cmd.start_pass) begin
            r_issuing <= 1'b1;
        end else if (r_issuing && w_rd_last) begin
            r_issuing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_pass) begin
            r_rd_word <= r_q;
            r_rd_base <= r_start_base;
        end else if (r_issuing) begin
            r_rd_word <= r_rd_word + WI'(1);
            r_rd_base <= r_rd_base + WB_L;
        end
    end

    // evaluate stage, aligned with the registered read data
    logic          r_ev_vld, r_ev_last;
    logic [WI-1:0] r_ev_word;
    logic [LW-1:0] r_ev_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_vld <= 1'b0;
        end else begin
            r_ev_vld <= r_issuing;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_word <= r_rd_word;
        r_ev_base <= r_rd_base;
        r_ev_last <= w_rd_last;
    end

    // map memory: zero map in the upper half of a row, claimed map in the lower
    logic [2*WB-1:0]      mem [MAP_WORDS];
    logic [2*WB-1:0]      r_rdata;
    logic                 r_rvld;
    logic [MAP_WORDS-1:0] r_row_vld;
    logic                 w_we;
    logic [2*WB-1:0]      w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_ev_word] <= w_wdata;
        end
        r_rdata <= mem[r_rd_word];
        r_rvld  <= r_row_vld[r_rd_word];
    end

    // row valid bits: an unwritten row reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_row_vld <= '0;
        end else if (w_we) begin
            r_row_vld[r_ev_word] <= 1'b1;
        end
    end

    // byte mask of the range within the word under evaluation
    logic [WB-1:0]        w_claimed, w_zero, w_mask;
    logic signed [LW:0]   w_dlo, w_dhi;
    logic                 w_conflict;

    assign w_claimed = r_rvld ? r_rdata[WB-1:0]    : '0;
    assign w_zero    = r_rvld ? r_rdata[2*WB-1:WB] : '0;
    assign w_dlo     = $signed({1'b0, r_lo}) - $signed({1'b0, r_ev_base});
    assign w_dhi     = $signed({1'b0, r_hi}) - $signed({1'b0, r_ev_base});

    always_comb begin
        logic signed [LW:0] bpos;
        for (int b = 0; b < WB; b++) begin
            bpos      = $signed((LW+1)'(b));
            w_mask[b] = (bpos >= w_dlo) && (bpos < w_dhi);
        end
    end

    // conflict rule per op
    always_comb begin
        case (r_op)
            brot_pkg::OP_CLAIM: w_conflict = |(w_mask & w_claimed);
            brot_pkg::OP_COVER: w_conflict = |(w_mask & w_claimed & ~w_zero);
            brot_pkg::OP_QUERY: w_conflict = |(w_mask & ~w_claimed);
            default:            w_conflict = 1'b0;
        endcase
    end

    // mark pass writes back the merged row
    assign w_we    = r_ev_vld && i_cmd.mark;
    assign w_wdata = {w_zero | ((r_op == brot_pkg::OP_COVER) ? w_mask : '0),
                      w_claimed | w_mask};

    // sticky failure over the check pass
    logic r_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start_pass) begin
            r_fail <= 1'b0;
        end else if (r_ev_vld && !i_cmd.mark && w_conflict) begin
            r_fail <= 1'b1;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.complete  = r_complete;
    assign o_stat.oob       = r_oob;
    assign o_stat.empty     = r_empty;
    assign o_stat.pass_done = r_ev_vld && r_ev_last;
    assign o_stat.fail      = r_fail || (r_ev_vld && !i_cmd.mark && w_conflict);

    // a mark pass only follows a clean check, so its rows show no conflict
    a_mark_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ev_vld && i_cmd.mark) |-> !w_conflict)
        else $error("conflict seen during mark pass");

    // every walked word overlaps the range
    a_mask_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (w_mask != '0))
        else $error("walked word outside range");

    // the walk never leaves the map
    a_word_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> (int'(r_rd_word) < MAP_WORDS))
        else $error("word index past end of map");

endmodule

>>> sv/brot_ctrl.sv
// Controller: sequences decide, check and mark passes; holds the result register.
// Depends on brot_pkg; drives brot_dpath through t_dp_cmd.
module brot_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_accepted,
    output logic [brot_pkg::ST_W-1:0]   o_status,
    input  logic                        i_track_en,
    input  brot_pkg::t_dp_stat          i_stat,
    output brot_pkg::t_dp_cmd           o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_START  = 6'b000100,
        S_CHECK  = 6'b001000,
        S_MARK   = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_res_acc, n_res_acc;
    logic [brot_pkg::ST_W-1:0]  r_res_status, n_res_status;
    logic                       r_out_valid, r_out_acc;
    logic [brot_pkg::ST_W-1:0]  r_out_status;
    logic                       w_out_load;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_load = (r_state == S_RESP) && (!r_out_valid || !i_out_stall);

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_res_acc    = r_res_acc;
        n_res_status = r_res_status;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_res_acc    = 1'b0;
                n_res_status = brot_pkg::ST_OK;
                n_state      = S_RESP;
                if (!i_track_en) begin
                    n_res_status = brot_pkg::ST_OFF;
                end else begin
                    case (i_stat.op)
                        brot_pkg::OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_res_acc   = 1'b1;
                        end
                        brot_pkg::OP_QUERY: begin
                            if (!i_stat.complete) begin
                                n_res_status = brot_pkg::ST_INCOMPLETE;
                            end else if (i_stat.empty) begin
                                n_res_acc = 1'b1;
                            end else begin
                                n_state = S_START;
                            end
                        end
                        default: begin
                            if (i_stat.oob) begin
                                n_res_status = brot_pkg::ST_BOUNDS;
                            end else if (i_stat.empty) begin
                                n_res_acc = 1'b1;
                            end else begin
                                n_state = S_START;
                            end
                        end
                    endcase
                end
            end
            S_START: begin
                o_cmd.start_pass = 1'b1;
                n_state          = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.pass_done) begin
                    if (i_stat.fail) begin
                        n_res_acc    = 1'b0;
                        n_res_status = (i_stat.op == brot_pkg::OP_QUERY) ?
                                       brot_pkg::ST_UNCOVERED : brot_pkg::ST_CONFLICT;
                        n_state      = S_RESP;
                    end else if (i_stat.op == brot_pkg::OP_QUERY) begin
                        n_res_acc    = 1'b1;
                        n_res_status = brot_pkg::ST_OK;
                        n_state      = S_RESP;
                    end else begin
                        o_cmd.start_pass = 1'b1;
                        n_state          = S_MARK;
                    end
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_stat.pass_done) begin
                    n_res_acc    = 1'b1;
                    n_res_status = brot_pkg::ST_OK;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_acc    <= n_res_acc;
        r_res_status <= n_res_status;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_acc    <= r_res_acc;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_out_acc;
    assign o_status    = r_out_status;

    // a new result beat only comes from the response state
    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> ($past(r_state) == S_RESP))
        else $error("result beat raised outside response state");

    // tracking off overrides every op
    a_off_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && !i_track_en) |=> (r_res_status == brot_pkg::ST_OFF))
        else $error("tracking off not reported");

    // a finished mark pass always reports success
    a_mark_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK && i_stat.pass_done) |=> (r_res_acc && r_res_status == brot_pkg::ST_OK))
        else $error("mark pass ended without success");

endmodule

>>> sv/byte_range_ownership_tracker.sv
// Top level of the byte range ownership tracker: APB registers and wiring.
// Tracking off, clear, query refusals, bounds and empty ranges are answered from the
// decide state without a walk. Query: a check pass; claim/cover: a check pass, then a
// mark pass if it is clean. Each pass walks the map words the range touches (one map memory port walk).
// One item in flight; the next is taken once its result sits in the output register.
// Reset: synchronous, clears both maps at once through per-row valid bits, and
// zeroes buffer_length and tracking_enabled.
module byte_range_ownership_tracker #(
    parameter int MAX_BYTES     = brot_pkg::MAX_BYTES_DEF,
    parameter int MAP_WORD_BITS = brot_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [brot_pkg::ADDR_W-1:0]         paddr,
    input  logic [brot_pkg::DATA_W-1:0]         pwdata,
    output logic [brot_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [brot_pkg::OP_W-1:0]           i_op,
    input  logic [brot_pkg::POS_W-1:0]          i_first_byte,
    input  logic [brot_pkg::POS_W-1:0]          i_byte_count,
    input  logic                                i_data_complete,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_accepted,
    output logic [brot_pkg::ST_W-1:0]           o_status
);

    logic [brot_pkg::POS_W-1:0] r_buffer_length;
    logic                       r_tracking_enabled;
    logic                       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length    <= '0;
            r_tracking_enabled <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                brot_pkg::REG_LENGTH: r_buffer_length    <= pwdata[brot_pkg::POS_W-1:0];
                brot_pkg::REG_ENABLE: r_tracking_enabled <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[2])
            brot_pkg::REG_LENGTH: prdata = brot_pkg::DATA_W'(r_buffer_length);
            brot_pkg::REG_ENABLE: prdata = brot_pkg::DATA_W'(r_tracking_enabled);
            default:              prdata = '0;
        endcase
    end

    brot_pkg::t_dp_cmd  w_cmd;
    brot_pkg::t_dp_stat w_stat;

    brot_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_accepted  (o_accepted),
        .o_status    (o_status),
        .i_track_en  (r_tracking_enabled),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    brot_dpath #(
        .MAX_BYTES     (MAX_BYTES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_op            (i_op),
        .i_first_byte    (i_first_byte),
        .i_byte_count    (i_byte_count),
        .i_data_complete (i_data_complete),
        .i_buffer_length (r_buffer_length),
        .o_stat          (w_stat)
    );

endmodule

>>> verif/byte_range_ownership_tracker_test.sv
// Self-checking bench for byte_range_ownership_tracker: APB register set-up,
// directed and random claim/cover/query/clear beats, checked against a local map model.
// Depends on brot_pkg and the tracker RTL only.
module byte_range_ownership_tracker_test;

    typedef struct packed {
        logic                      accepted;
        logic [brot_pkg::ST_W-1:0] status;
    } t_verdict;

    // clock, reset and block ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [brot_pkg::ADDR_W-1:0]   paddr = '0;
    logic [brot_pkg::DATA_W-1:0]   pwdata = '0;
    logic [brot_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [brot_pkg::OP_W-1:0]     i_op = brot_pkg::OP_CLAIM;
    logic [brot_pkg::POS_W-1:0]    i_first_byte = '0;
    logic [brot_pkg::POS_W-1:0]    i_byte_count = '0;
    logic                          i_data_complete = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_accepted;
    logic [brot_pkg::ST_W-1:0]     o_status;

    // local copy of the registers and both byte maps
    int       cfg_length = 0;
    bit       cfg_enable = 1'b0;
    bit       owned_bytes [brot_pkg::MAX_BYTES_DEF];
    bit       zero_bytes  [brot_pkg::MAX_BYTES_DEF];

    t_verdict pending_verdicts[$];
    int       n_beats = 0;
    int       n_results = 0;
    int       n_mismatch = 0;
    int       status_seen [8];
    int       send_gap_pct = 0;
    int       recv_stall_pct = 0;

    byte_range_ownership_tracker u_top (.*);

    // 4-unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result-side stall, redrawn every falling edge
    always @(negedge i_clk) begin
        i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // effective buffer length: oversized lengths saturate at the map size
    function automatic int tracked_len();
        return (cfg_length > brot_pkg::MAX_BYTES_DEF) ? brot_pkg::MAX_BYTES_DEF : cfg_length;
    endfunction

    // map model: applies one op and returns what the block should answer
    function automatic t_verdict apply_range_op(logic [brot_pkg::OP_W-1:0] op, int first,
                                                int count, logic complete);
        t_verdict v;
        int       lim;
        int       stop;
        bit       clash;
        v.accepted = 1'b0;
        v.status   = brot_pkg::ST_OK;
        lim        = tracked_len();
        stop       = first + count;
        clash      = 1'b0;
        if (!cfg_enable) begin
            v.status = brot_pkg::ST_OFF;
        end else if (op == brot_pkg::OP_CLEAR) begin
            owned_bytes = '{default: 1'b0};
            zero_bytes  = '{default: 1'b0};
            v.accepted  = 1'b1;
        end else if (op == brot_pkg::OP_QUERY) begin
            if (!complete) begin
                v.status = brot_pkg::ST_INCOMPLETE;
            end else begin
                v.accepted = 1'b1;
                for (int p = 0; p < lim; p++) begin
                    if (!owned_bytes[p]) begin
                        v.accepted = 1'b0;
                        v.status   = brot_pkg::ST_UNCOVERED;
                        break;
                    end
                end
            end
        end else if (first > lim || stop > lim) begin
            v.status = brot_pkg::ST_BOUNDS;
        end else begin
            // check pass first, marks only if the whole range is free
            for (int p = first; p < stop; p++) begin
                if (op == brot_pkg::OP_CLAIM ? owned_bytes[p]
                                             : (owned_bytes[p] && !zero_bytes[p])) begin
                    clash = 1'b1;
                    break;
                end
            end
            if (clash) begin
                v.status = brot_pkg::ST_CONFLICT;
            end else begin
                for (int p = first; p < stop; p++) begin
                    owned_bytes[p] = 1'b1;
                    if (op == brot_pkg::OP_COVER) zero_bytes[p] = 1'b1;
                end
                v.accepted = 1'b1;
            end
        end
        return v;
    endfunction

    // APB write: setup then access phase
    task automatic write_reg(input logic idx, input int value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == brot_pkg::REG_LENGTH) cfg_length = value & 32'h1FFF;
        else cfg_enable = value[0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drive one input beat, hold it until taken, then book its expected result
    task automatic send_beat(input logic [brot_pkg::OP_W-1:0] op, input int first,
                             input int count, input logic complete);
        @(negedge i_clk);
        // sender idles cycle by cycle before offering the beat
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_op            = op;
        i_first_byte    = first[brot_pkg::POS_W-1:0];
        i_byte_count    = count[brot_pkg::POS_W-1:0];
        i_data_complete = complete;
        i_in_valid      = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_verdicts.push_back(apply_range_op(i_op, int'(i_first_byte),
                                                  int'(i_byte_count), i_data_complete));
        n_beats++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // quiesce before a register write
    task automatic drain();
        stop_sending();
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            status_seen[o_status]++;
            if (pending_verdicts.size() == 0) begin
                $error("result beat with nothing pending: accepted %0b status %0d",
                       o_accepted, o_status);
                n_mismatch++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0b, got %0b", want.accepted, o_accepted);
                    n_mismatch++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_mismatch++;
                end
            end
        end
    end

    // every op refused while tracking is off; clear must not touch the maps either
    task automatic test_tracking_off();
        send_beat(brot_pkg::OP_CLAIM, 0, 1, 1'b0);
        send_beat(brot_pkg::OP_COVER, 0, 0, 1'b1);
        send_beat(brot_pkg::OP_QUERY, 0, 0, 1'b1);
        send_beat(brot_pkg::OP_CLEAR, 0, 0, 1'b0);
        drain();
        write_reg(brot_pkg::REG_LENGTH, 64);
        write_reg(brot_pkg::REG_ENABLE, 1);
        send_beat(brot_pkg::OP_CLAIM, 0, 64, 1'b1);
        drain();
        write_reg(brot_pkg::REG_ENABLE, 0);
        send_beat(brot_pkg::OP_CLEAR, 0, 0, 1'b1);
        drain();
        write_reg(brot_pkg::REG_ENABLE, 1);
        send_beat(brot_pkg::OP_QUERY, 8191, 8191, 1'b1);   // still covered
    endtask

    // full-size buffer: bounds, empty ranges, conflicts and coverage
    task automatic test_conflicts_and_coverage();
        drain();
        write_reg(brot_pkg::REG_LENGTH, brot_pkg::MAX_BYTES_DEF);
        send_beat(brot_pkg::OP_CLEAR, 8191, 8191, 1'b0);
        send_beat(brot_pkg::OP_CLAIM, 0, 0, 1'b0);
        send_beat(brot_pkg::OP_CLAIM, 4096, 0, 1'b0);
        send_beat(brot_pkg::OP_CLAIM, 4096, 1, 1'b0);
        send_beat(brot_pkg::OP_COVER, 8191, 8191, 1'b1);
        send_beat(brot_pkg::OP_QUERY, 0, 0, 1'b0);
        send_beat(brot_pkg::OP_QUERY, 0, 0, 1'b1);
        send_beat(brot_pkg::OP_COVER, 100, 100, 1'b0);
        send_beat(brot_pkg::OP_CLAIM, 150, 10, 1'b0);     // hits covered bytes
        send_beat(brot_pkg::OP_COVER, 150, 10, 1'b0);     // zero over zero is fine
        send_beat(brot_pkg::OP_CLAIM, 0, 100, 1'b0);
        send_beat(brot_pkg::OP_COVER, 50, 60, 1'b0);      // claimed, not zero
        send_beat(brot_pkg::OP_CLAIM, 200, 3896, 1'b0);
        send_beat(brot_pkg::OP_QUERY, 0, 0, 1'b1);
        send_beat(brot_pkg::OP_CLEAR, 0, 0, 1'b1);
        send_beat(brot_pkg::OP_QUERY, 0, 0, 1'b1);
    endtask

    // empty buffer and a length beyond the map
    task automatic test_length_extremes();
        drain();
        write_reg(brot_pkg::REG_LENGTH, 0);
        send_beat(brot_pkg::OP_QUERY, 0, 0, 1'b1);
        send_beat(brot_pkg::OP_CLAIM, 0, 0, 1'b0);
        send_beat(brot_pkg::OP_CLAIM, 0, 1, 1'b0);
        send_beat(brot_pkg::OP_COVER, 1, 0, 1'b0);
        drain();
        write_reg(brot_pkg::REG_LENGTH, 8191);
        send_beat(brot_pkg::OP_CLAIM, 4095, 1, 1'b0);
        send_beat(brot_pkg::OP_CLAIM, 4096, 1, 1'b0);
        send_beat(brot_pkg::OP_QUERY, 0, 0, 1'b1);
    endtask

    // clear, then walk the buffer in chunks; sometimes leaves a hole
    task automatic fill_run();
        int  cursor;
        int  chunk;
        bit  holed;
        cursor = 0;
        holed  = ($urandom_range(4) == 0);
        send_beat(brot_pkg::OP_CLEAR, $urandom_range(8191), $urandom_range(8191),
                  1'($urandom_range(1)));
        while (cursor < tracked_len()) begin
            chunk = $urandom_range(1, 96);
            if (chunk > tracked_len() - cursor) chunk = tracked_len() - cursor;
            if (holed && $urandom_range(7) == 0) begin
                cursor += 1;
                holed   = 1'b0;
                continue;
            end
            send_beat($urandom_range(1) ? brot_pkg::OP_COVER : brot_pkg::OP_CLAIM,
                      cursor, chunk, 1'b0);
            cursor += chunk;
        end
        send_beat(brot_pkg::OP_QUERY, $urandom_range(8191), $urandom_range(8191), 1'b1);
    endtask

    // one random beat, mostly in-range with random content
    task automatic random_beat();
        int r;
        int f;
        int room;
        int c;
        r    = $urandom_range(99);
        f    = $urandom_range(tracked_len());
        room = tracked_len() - f;
        c    = ($urandom_range(3) == 0) ? $urandom_range(room)
                                        : $urandom_range(room < 24 ? room : 24);
        if (r < 35) begin
            send_beat(brot_pkg::OP_CLAIM, f, c, 1'($urandom_range(1)));
        end else if (r < 55) begin
            send_beat(brot_pkg::OP_COVER, f, c, 1'($urandom_range(1)));
        end else if (r < 65) begin
            send_beat(brot_pkg::OP_QUERY, $urandom_range(8191), $urandom_range(8191),
                      $urandom_range(9) != 0);
        end else if (r < 68) begin
            send_beat(brot_pkg::OP_CLEAR, $urandom_range(8191), $urandom_range(8191),
                      1'($urandom_range(1)));
        end else if (r < 80) begin
            // raw noise across the whole field range
            send_beat(brot_pkg::OP_W'($urandom_range(3)), $urandom_range(8191),
                      $urandom_range(8191), 1'($urandom_range(1)));
        end else begin
            // ranges ending right at, or just past, the buffer end
            f = tracked_len() - $urandom_range(3);
            if (f < 0) f = 0;
            send_beat($urandom_range(1) ? brot_pkg::OP_COVER : brot_pkg::OP_CLAIM, f,
                      tracked_len() - f + $urandom_range(0, 2), 1'b0);
        end
    endtask

    // random traffic under one length and one idling pattern
    task automatic test_random_traffic(input int length, input int n, input int gap_pct,
                                       input int stall_pct, input bit hold_mid);
        int target;
        bit held;
        drain();
        write_reg(brot_pkg::REG_LENGTH, length);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        target         = n_beats + n;
        held           = 1'b0;
        while (n_beats < target) begin
            if ($urandom_range(99) < 6) fill_run();
            else random_beat();
            // hold back until the block has answered everything
            if (hold_mid && !held && n_beats >= target - n / 2) begin
                drain();
                held = 1'b1;
            end
        end
    endtask

    // run order
    initial begin
        owned_bytes = '{default: 1'b0};
        zero_bytes  = '{default: 1'b0};
        status_seen = '{default: 0};
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_tracking_off();
        test_conflicts_and_coverage();
        test_length_extremes();
        test_random_traffic(300, 575, 21, 88, 1'b1);
        test_random_traffic(brot_pkg::MAX_BYTES_DEF, 575, 88, 21, 1'b0);
        test_random_traffic($urandom_range(1, 600), 575, 0, 0, 1'b0);

        drain();
        repeat (150) @(posedge i_clk);
        $display("byte_range_ownership_tracker_test: summary: %0d beats in, %0d results checked",
                 n_beats, n_results);
        $display("  status ok %0d, off %0d, bounds %0d, conflict %0d, incomplete %0d, uncovered %0d",
                 status_seen[brot_pkg::ST_OK], status_seen[brot_pkg::ST_OFF],
                 status_seen[brot_pkg::ST_BOUNDS], status_seen[brot_pkg::ST_CONFLICT],
                 status_seen[brot_pkg::ST_INCOMPLETE], status_seen[brot_pkg::ST_UNCOVERED]);
        if (n_mismatch == 0 && pending_verdicts.size() == 0) begin
            $display("byte_range_ownership_tracker_test: clean");
        end else begin
            $display("byte_range_ownership_tracker_test: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("byte_range_ownership_tracker_test: errors");
        $finish;
    end

endmodule
